// ===== rtl/mscs_pkg.sv =====
// Shared types, codes and constants of the motor speed command supervisor.
package mscs_pkg;

  localparam int unsigned SPD_W   = 20;
  localparam int unsigned MAXS_W  = 19;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned GAIN_W  = 17;
  localparam int unsigned IDLE_W  = 17;
  localparam int unsigned VEL_W   = 21;
  localparam int unsigned CUR_W   = 15;
  localparam int unsigned TRQ_W   = 14;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned CFGI_W  = 2;
  localparam int unsigned CFGD_W  = 19;
  localparam int unsigned IN_DW   = 24;
  localparam int unsigned IN_UW   = 3;
  localparam int unsigned OUT_DW  = 128;

  // Configuration register indexes.
  localparam logic [CFGI_W-1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_GAIN      = 2'd2;

  localparam logic [MAXS_W-1:0] MAX_SPEED_RST = 19'd48000;
  localparam logic [TMO_W-1:0]  TIMEOUT_RST   = 16'd500;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 17'd6863;

  localparam logic [IDLE_W-1:0] IDLE_MAX      = 17'h1FFFF;
  // Lag step is 123/1024 of the error.
  localparam logic signed [28:0] LAG_NUM      = 29'sd123;
  localparam logic signed [28:0] LAG_HALF     = 29'sd512;
  // floor(n/3) = (n * 43691) >> 17 for every n below 2^17.
  localparam logic [15:0] DIV3_RECIP          = 16'd43691;
  localparam logic [CUR_W-1:0] CUR_BASE       = 15'd200;

  typedef enum logic [2:0] {
    FUNC_SET_SPEED = 3'd0,
    FUNC_FORWARD   = 3'd1,
    FUNC_REVERSE   = 3'd2,
    FUNC_HOLD      = 3'd3,
    FUNC_HEARTBEAT = 3'd4,
    FUNC_CLEAR     = 3'd5,
    FUNC_ESTOP     = 3'd6,
    FUNC_TICK      = 3'd7
  } func_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_FORWARD = 3'd1,
    MODE_REVERSE = 3'd2,
    MODE_HOLD    = 3'd3,
    MODE_ESTOP   = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAG,
    ST_UPD,
    ST_MUL,
    ST_FIN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;      // apply the accepted command to the supervisor state
    logic lag_mul;   // form the lag product from the tracking error
    logic lag_upd;   // add the lag step to the measured speed
    logic derive;    // form velocity, current and torque products
    logic load;      // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_is_tick;
    logic out_full;
  } dp_sts_t;

endpackage

// ===== rtl/motor_speed_command_supervisor_core.sv =====
// Top level of the motor speed command supervisor.
//
// The block takes one drive command or control tick per input transfer and
// returns one status item per command. A tick forms the lag product, updates
// the measured speed and forms the derived products before it loads the result
// register; other commands skip the lag model, form the derived products and
// load the result. The next command is taken only once the result is loaded.
// The chain of dependent multiplications in the datapath sets this sequence.
// The result register parts the two sides, so a new command is taken while an
// earlier result still waits; the block holds in its last step only when that
// register is still full and not being taken. Configuration writes are taken
// in any cycle and belong in periods when the block is idle.
module motor_speed_command_supervisor_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: speed_request[19:0], estop_request[20], zero[23:21]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mscs_pkg::IN_DW-1:0]    in_tdata,
  // in_tuser: func[2:0]
  input  logic [mscs_pkg::IN_UW-1:0]    in_tuser,
  // out_tdata: accepted[0], mode[3:1], target_speed[23:4],
  // measured_speed[43:24], motor_velocity[64:44], current_ma[79:65],
  // torque_mnm[93:80], timed_out[94], tick_count[126:95], zero[127]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mscs_pkg::OUT_DW-1:0]   out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mscs_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [mscs_pkg::CFGD_W-1:0]   cfg_data
);
  import mscs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  mscs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mscs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== rtl/mscs_ctrl.sv =====
// Sequencing controller of the motor speed command supervisor.
module mscs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic             out_tready,
  input  mscs_pkg::dp_sts_t sts,
  output mscs_pkg::dp_cmd_t cmd
);
  import mscs_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;
  logic        out_free;

  assign accept   = in_tvalid && (state_r == ST_IDLE);
  assign out_free = !sts.out_full || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = sts.in_is_tick ? ST_LAG : ST_MUL;
        end
      end
      ST_LAG:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.exec  = in_tvalid;
      end
      ST_LAG:  cmd.lag_mul = 1'b1;
      ST_UPD:  cmd.lag_upd = 1'b1;
      ST_MUL:  cmd.derive  = 1'b1;
      ST_FIN:  cmd.load    = out_free;
      default: cmd         = '0;
    endcase
  end

endmodule

// ===== rtl/mscs_dp.sv =====
// Datapath of the motor speed command supervisor: state, lag model, derived values.
module mscs_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mscs_pkg::IN_DW-1:0]    in_tdata,
  input  logic [mscs_pkg::IN_UW-1:0]    in_tuser,
  input  logic                          cfg_we,
  input  logic [mscs_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [mscs_pkg::CFGD_W-1:0]   cfg_data,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [mscs_pkg::OUT_DW-1:0]   out_tdata,
  input  mscs_pkg::dp_cmd_t             cmd,
  output mscs_pkg::dp_sts_t             sts
);
  import mscs_pkg::*;

  // Configuration registers.
  logic [MAXS_W-1:0] max_speed_r;
  logic [TMO_W-1:0]  timeout_r;
  logic [GAIN_W-1:0] gain_r;

  // Supervisor state.
  logic               estop_r, estop_nxt;
  mode_t              mode_r, mode_nxt;
  logic signed [SPD_W-1:0] target_r, target_nxt;
  logic signed [SPD_W-1:0] speed_r, speed_nxt;
  logic [IDLE_W-1:0]  idle_r, idle_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic               acc_r, acc_nxt;
  logic               tout_r, tout_nxt;

  // Arithmetic stages.
  logic signed [28:0] lag_r;
  logic [36:0]        vprod_r;
  logic [32:0]        cprod_r;
  logic [32:0]        tprod_r;
  logic               neg_r;

  // Result register.
  logic               out_valid_r;
  logic [OUT_DW-1:0]  out_data_r;

  func_t                   func;
  logic signed [SPD_W-1:0] req_in;
  logic                    est_in;
  logic signed [SPD_W:0]   req, req_abs, lim, clamped;
  logic [IDLE_W-1:0]       idle_inc;
  logic                    fire;
  logic signed [SPD_W:0]   err;
  logic [SPD_W-1:0]        mag;
  logic [22:0]             mag5;
  logic [37:0]             vsum;
  logic [21:0]             vmag;
  logic [VEL_W-1:0]        vel;
  logic [CUR_W-1:0]        cur;
  logic [TRQ_W-1:0]        trq;

  assign func   = func_t'(in_tuser);
  assign req_in = $signed(in_tdata[SPD_W-1:0]);
  assign est_in = in_tdata[SPD_W];

  assign sts.in_is_tick = (func == FUNC_TICK);
  assign sts.out_full   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r <= MAX_SPEED_RST;
      timeout_r   <= TIMEOUT_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_SPEED: max_speed_r <= cfg_data[MAXS_W-1:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data[TMO_W-1:0];
        CFG_GAIN:      gain_r      <= cfg_data[GAIN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Speed request shaping and clamping.
  always_comb begin
    req     = 21'(req_in);
    req_abs = req[SPD_W] ? -req : req;
    case (func)
      FUNC_FORWARD: req = req_abs;
      FUNC_REVERSE: req = -req_abs;
      default:      ;
    endcase
    lim     = $signed({2'b00, max_speed_r});
    clamped = req;
    if (req > lim) begin
      clamped = lim;
    end else if (req < -lim) begin
      clamped = -lim;
    end
  end

  assign idle_inc = (idle_r == IDLE_MAX) ? idle_r : idle_r + 1'b1;
  assign fire     = (timeout_r != '0) && (target_r != '0) &&
                    (idle_inc > IDLE_W'(timeout_r));

  // Command execution at the transfer of an input item.
  always_comb begin
    estop_nxt  = estop_r;
    mode_nxt   = mode_r;
    target_nxt = target_r;
    speed_nxt  = speed_r;
    idle_nxt   = idle_r;
    tick_nxt   = tick_r;
    acc_nxt    = 1'b1;
    tout_nxt   = 1'b0;
    unique case (func)
      FUNC_SET_SPEED, FUNC_FORWARD, FUNC_REVERSE: begin
        if (estop_r) begin
          acc_nxt = 1'b0;
        end else begin
          target_nxt = clamped[SPD_W-1:0];
          if (clamped > 0) begin
            mode_nxt = MODE_FORWARD;
          end else if (clamped < 0) begin
            mode_nxt = MODE_REVERSE;
          end else begin
            mode_nxt = MODE_IDLE;
          end
          idle_nxt = '0;
        end
      end
      FUNC_HOLD: begin
        if (estop_r) begin
          acc_nxt = 1'b0;
        end else begin
          target_nxt = '0;
          mode_nxt   = MODE_HOLD;
          idle_nxt   = '0;
        end
      end
      FUNC_HEARTBEAT: begin
        if (estop_r) begin
          acc_nxt = 1'b0;
        end else begin
          idle_nxt = '0;
        end
      end
      FUNC_CLEAR: begin
        if (estop_r) begin
          acc_nxt = 1'b0;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      FUNC_ESTOP: begin
        estop_nxt  = est_in;
        idle_nxt   = '0;
        target_nxt = '0;
        if (est_in) begin
          speed_nxt = '0;
          mode_nxt  = MODE_ESTOP;
        end else begin
          mode_nxt  = MODE_IDLE;
        end
      end
      FUNC_TICK: begin
        tick_nxt = tick_r + 1'b1;
        idle_nxt = idle_inc;
        if (fire) begin
          target_nxt = '0;
          mode_nxt   = MODE_HOLD;
          tout_nxt   = 1'b1;
        end
        // The lag step follows in later cycles; while stopped the speed is pinned.
        if (estop_r) begin
          speed_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  assign err = {target_r[SPD_W-1], target_r} - {speed_r[SPD_W-1], speed_r};
  assign mag = speed_r[SPD_W-1] ? SPD_W'(-speed_r) : speed_r;
  assign mag5 = {1'b0, mag, 2'b00} + 23'(mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      estop_r  <= 1'b0;
      mode_r   <= MODE_IDLE;
      target_r <= '0;
      speed_r  <= '0;
      idle_r   <= '0;
      tick_r   <= '0;
    end else if (cmd.exec) begin
      estop_r  <= estop_nxt;
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
      speed_r  <= speed_nxt;
      idle_r   <= idle_nxt;
      tick_r   <= tick_nxt;
    end else if (cmd.lag_upd && !estop_r) begin
      // Arithmetic shift by ten rounds the biased product down.
      speed_r <= speed_r + $signed({lag_r[28], lag_r[28:10]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r  <= acc_nxt;
      tout_r <= tout_nxt;
    end
    if (cmd.lag_mul) begin
      lag_r <= 29'(err) * LAG_NUM + LAG_HALF;
    end
    if (cmd.derive) begin
      vprod_r <= 37'(mag) * 37'(gain_r);
      cprod_r <= 33'(mag5[22:5]) * 33'(DIV3_RECIP);
      tprod_r <= 33'(mag[SPD_W-1:4]) * 33'(DIV3_RECIP);
      neg_r   <= speed_r[SPD_W-1];
    end
  end

  // Rounding, saturation and the stopped case of the derived values.
  always_comb begin
    vsum = {1'b0, vprod_r} + 38'd32768;
    vmag = vsum[37:16];
    if (!neg_r) begin
      vel = (vmag > 22'd1048575) ? 21'h0FFFFF : vmag[VEL_W-1:0];
    end else begin
      vel = (vmag > 22'd1048576) ? 21'h100000 : VEL_W'(-vmag);
    end
    cur = CUR_BASE + cprod_r[31:17];
    trq = tprod_r[30:17];
    if (estop_r) begin
      vel = '0;
      cur = '0;
      trq = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= {1'b0, tick_r, tout_r, trq, cur, vel, speed_r, target_r,
                     mode_r, acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/mscs_checker.sv =====
// Port-level checks of the motor speed command supervisor and their binding.
module mscs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [mscs_pkg::IN_DW-1:0]    in_tdata,
  input logic [mscs_pkg::IN_UW-1:0]    in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mscs_pkg::OUT_DW-1:0]   out_tdata,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [mscs_pkg::CFGI_W-1:0]   cfg_index,
  input logic [mscs_pkg::CFGD_W-1:0]   cfg_data
);
  import mscs_pkg::*;

  logic [2:0] out_mode;
  assign out_mode = out_tdata[3:1];

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // A watchdog expiry leaves the drive holding at zero target.
  a_timeout_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[94] |->
      out_mode == MODE_HOLD && out_tdata[23:4] == '0 && out_tdata[0])
    else $error("timeout without hold at zero target");

  // While stopped, the measured speed and the derived values read zero.
  a_estop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_mode == MODE_ESTOP |->
      out_tdata[93:44] == '0 && out_tdata[43:24] == '0)
    else $error("nonzero motor values during emergency stop");

endmodule

bind motor_speed_command_supervisor_core mscs_checker u_mscs_checker (.*);

// ===== tb/motor_speed_command_supervisor_core_tb.sv =====
// Self-checking testbench for the motor speed command supervisor core.
module motor_speed_command_supervisor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mscs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam longint VEL_HI = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint VEL_LO = -(longint'(1) << (VEL_W - 1));

  typedef struct packed {
    logic              accepted;
    mode_t             mode;
    logic [SPD_W-1:0]  target;
    logic [SPD_W-1:0]  measured;
    logic [VEL_W-1:0]  velocity;
    logic [CUR_W-1:0]  current;
    logic [TRQ_W-1:0]  torque;
    logic              timed_out;
    logic [TICK_W-1:0] ticks;
  } status_t;

  // One command; acc, mode and target hold typed-in values where known is set.
  typedef struct packed {
    func_t            func;
    logic [SPD_W-1:0] req;
    logic             est;
    logic             known;
    logic             acc;
    mode_t            mode;
    logic [SPD_W-1:0] target;
  } drive_cmd_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic [IN_UW-1:0]    in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFGI_W-1:0]   cfg_index = '0;
  logic [CFGD_W-1:0]   cfg_data = '0;

  // Predicted supervisor state and register copies.
  logic              stop_on = 1'b0;
  mode_t             drive = MODE_IDLE;
  longint            target_spd = 0;
  longint            meas_spd = 0;
  longint            idle_cnt = 0;
  logic [TICK_W-1:0] tick_total = '0;
  longint            max_speed = longint'(MAX_SPEED_RST);
  longint            tmo_ticks = longint'(TIMEOUT_RST);
  longint            gain = longint'(GAIN_RST);

  status_t     status_due[$];
  int unsigned mismatch_count = 0;
  int unsigned result_count = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  drive_cmd_t directed_cmds [25] = '{
    '{FUNC_TICK,      20'h00000,    1'b0, 1'b1, 1'b1, MODE_IDLE,    20'd0},
    '{FUNC_SET_SPEED, 20'h7FFFF,    1'b0, 1'b1, 1'b1, MODE_FORWARD, 20'd48000},
    '{FUNC_TICK,      20'h00000,    1'b1, 1'b0, 1'b0, MODE_IDLE,    20'd0},
    '{FUNC_SET_SPEED, 20'h80000,    1'b0, 1'b1, 1'b1, MODE_REVERSE, -20'sd48000},
    '{FUNC_TICK,      20'h7FFFF,    1'b0, 1'b0, 1'b0, MODE_IDLE,    20'd0},
    '{FUNC_FORWARD,   -20'sd1000,   1'b0, 1'b1, 1'b1, MODE_FORWARD, 20'd1000},
    '{FUNC_REVERSE,   20'd1000,     1'b1, 1'b1, 1'b1, MODE_REVERSE, -20'sd1000},
    '{FUNC_REVERSE,   20'h80000,    1'b0, 1'b1, 1'b1, MODE_REVERSE, -20'sd48000},
    '{FUNC_FORWARD,   20'h80000,    1'b0, 1'b1, 1'b1, MODE_FORWARD, 20'd48000},
    '{FUNC_TICK,      20'h00000,    1'b0, 1'b0, 1'b0, MODE_IDLE,    20'd0},
    '{FUNC_HOLD,      20'h7FFFF,    1'b0, 1'b1, 1'b1, MODE_HOLD,    20'd0},
    '{FUNC_HEARTBEAT, 20'h00000,    1'b0, 1'b1, 1'b1, MODE_HOLD,    20'd0},
    '{FUNC_CLEAR,     20'h00000,    1'b0, 1'b1, 1'b1, MODE_IDLE,    20'd0},
    '{FUNC_SET_SPEED, 20'h00000,    1'b0, 1'b1, 1'b1, MODE_IDLE,    20'd0},
    '{FUNC_SET_SPEED, 20'd20000,    1'b0, 1'b1, 1'b1, MODE_FORWARD, 20'd20000},
    '{FUNC_TICK,      20'h00000,    1'b0, 1'b0, 1'b0, MODE_IDLE,    20'd0},
    '{FUNC_ESTOP,     20'd20000,    1'b1, 1'b1, 1'b1, MODE_ESTOP,   20'd0},
    '{FUNC_SET_SPEED, 20'd5000,     1'b0, 1'b1, 1'b0, MODE_ESTOP,   20'd0},
    '{FUNC_FORWARD,   20'd5000,     1'b1, 1'b1, 1'b0, MODE_ESTOP,   20'd0},
    '{FUNC_HOLD,      20'h00000,    1'b0, 1'b1, 1'b0, MODE_ESTOP,   20'd0},
    '{FUNC_HEARTBEAT, 20'h00000,    1'b0, 1'b1, 1'b0, MODE_ESTOP,   20'd0},
    '{FUNC_CLEAR,     20'h00000,    1'b0, 1'b1, 1'b0, MODE_ESTOP,   20'd0},
    '{FUNC_TICK,      20'h00000,    1'b0, 1'b1, 1'b1, MODE_ESTOP,   20'd0},
    '{FUNC_ESTOP,     20'h00000,    1'b0, 1'b1, 1'b1, MODE_IDLE,    20'd0},
    '{FUNC_SET_SPEED, 20'hFFFFF,    1'b0, 1'b1, 1'b1, MODE_REVERSE, -20'sd1}
  };

  motor_speed_command_supervisor_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("motor_speed_command_supervisor_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 20);
  end

  function automatic status_t predict_status(func_t f, logic [SPD_W-1:0] req_bits,
                                             logic est);
    status_t r;
    longint  req;
    longint  mag;
    longint  v;
    r = '0;
    r.accepted = 1'b1;
    req = longint'(signed'(req_bits));
    case (f)
      FUNC_SET_SPEED, FUNC_FORWARD, FUNC_REVERSE: begin
        if (stop_on) begin
          r.accepted = 1'b0;
        end else begin
          if (f == FUNC_FORWARD && req < 0) req = -req;
          if (f == FUNC_REVERSE && req > 0) req = -req;
          if (req > max_speed) req = max_speed;
          if (req < -max_speed) req = -max_speed;
          target_spd = req;
          drive = (req > 0) ? MODE_FORWARD : ((req < 0) ? MODE_REVERSE : MODE_IDLE);
          idle_cnt = 0;
        end
      end
      FUNC_HOLD: begin
        if (stop_on) begin
          r.accepted = 1'b0;
        end else begin
          target_spd = 0;
          drive = MODE_HOLD;
          idle_cnt = 0;
        end
      end
      FUNC_HEARTBEAT: begin
        if (stop_on) r.accepted = 1'b0;
        else idle_cnt = 0;
      end
      FUNC_CLEAR: begin
        if (stop_on) r.accepted = 1'b0;
        else drive = MODE_IDLE;
      end
      FUNC_ESTOP: begin
        stop_on = est;
        idle_cnt = 0;
        target_spd = 0;
        if (est) begin
          meas_spd = 0;
          drive = MODE_ESTOP;
        end else begin
          drive = MODE_IDLE;
        end
      end
      default: begin
        tick_total = tick_total + 1'b1;
        if (idle_cnt < longint'(IDLE_MAX)) idle_cnt++;
        if (tmo_ticks != 0 && target_spd != 0 && idle_cnt > tmo_ticks) begin
          target_spd = 0;
          drive = MODE_HOLD;
          r.timed_out = 1'b1;
        end
        // First-order lag: floor((123 * error + 512) / 1024).
        if (stop_on) meas_spd = 0;
        else meas_spd = meas_spd + (((target_spd - meas_spd) * 123 + 512) >>> 10);
      end
    endcase

    if (!stop_on) begin
      mag = (meas_spd < 0) ? -meas_spd : meas_spd;
      v = (mag * gain + 32768) / 65536;
      if (meas_spd < 0) v = -v;
      if (v > VEL_HI) v = VEL_HI;
      if (v < VEL_LO) v = VEL_LO;
      r.velocity = v[VEL_W-1:0];
      r.current = CUR_W'(longint'(CUR_BASE) + (mag * 5) / 96);
      r.torque = TRQ_W'(mag / 48);
    end
    r.mode = drive;
    r.target = target_spd[SPD_W-1:0];
    r.measured = meas_spd[SPD_W-1:0];
    r.ticks = tick_total;
    return r;
  endfunction

  function automatic drive_cmd_t random_cmd();
    drive_cmd_t  c;
    int unsigned pick;
    longint      spd;
    c = '0;
    c.est = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 48) c.func = FUNC_TICK;
    else if (pick < 60) c.func = FUNC_SET_SPEED;
    else if (pick < 68) c.func = FUNC_FORWARD;
    else if (pick < 76) c.func = FUNC_REVERSE;
    else if (pick < 81) c.func = FUNC_HOLD;
    else if (pick < 88) c.func = FUNC_HEARTBEAT;
    else if (pick < 92) c.func = FUNC_CLEAR;
    else begin
      c.func = FUNC_ESTOP;
      // Keep the stop engaged for short spells so motion commands get through.
      c.est = stop_on ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 2) == 0);
    end
    case ($urandom_range(0, 5))
      0: c.req = SPD_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: c.req = 20'h7FFFF;
          1: c.req = 20'h80000;
          2: c.req = 20'h00001;
          3: c.req = 20'hFFFFF;
          default: c.req = 20'h00000;
        endcase
      end
      default: begin
        spd = longint'($urandom_range(0, int'(max_speed) + 200));
        if ($urandom_range(0, 1) == 1) spd = -spd;
        c.req = spd[SPD_W-1:0];
      end
    endcase
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got 'h%0h, want 'h%0h",
                                result_count, name, got, want));
    end
  endtask

  always @(posedge clk) begin
    status_t got;
    status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.accepted  = out_tdata[0];
      got.mode      = mode_t'(out_tdata[3:1]);
      got.target    = out_tdata[23:4];
      got.measured  = out_tdata[43:24];
      got.velocity  = out_tdata[64:44];
      got.current   = out_tdata[79:65];
      got.torque    = out_tdata[93:80];
      got.timed_out = out_tdata[94];
      got.ticks     = out_tdata[126:95];
      if (status_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", result_count));
      end else begin
        want = status_due.pop_front();
        check_field("accepted", got.accepted, want.accepted);
        check_field("mode", got.mode, want.mode);
        check_field("target_speed", got.target, want.target);
        check_field("measured_speed", got.measured, want.measured);
        check_field("motor_velocity", got.velocity, want.velocity);
        check_field("current_ma", got.current, want.current);
        check_field("torque_mnm", got.torque, want.torque);
        check_field("timed_out", got.timed_out, want.timed_out);
        check_field("tick_count", got.ticks, want.ticks);
      end
      result_count++;
    end
  end

  task automatic send_cmd(drive_cmd_t c);
    status_t want;
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, c.est, c.req};
    in_tuser  <= c.func;
    do @(posedge clk); while (!in_tready);
    want = predict_status(c.func, c.req, c.est);
    if (c.known) begin
      want.accepted = c.acc;
      want.mode = c.mode;
      want.target = c.target;
    end
    status_due.push_back(want);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes never toggle it within a step.
  task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFGD_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MAX_SPEED: max_speed = longint'(value[MAXS_W-1:0]);
      CFG_TIMEOUT:   tmo_ticks = longint'(value[TMO_W-1:0]);
      CFG_GAIN:      gain = longint'(value[GAIN_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned spd_lim, int unsigned tmo, int unsigned g);
    write_reg(CFG_MAX_SPEED, CFGD_W'(spd_lim));
    write_reg(CFG_TIMEOUT, CFGD_W'(tmo));
    write_reg(CFG_GAIN, CFGD_W'(g));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_cmds[i]) send_cmd(directed_cmds[i]);

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) wait_drained();
      case (phase)
        1: set_config(524287, 0, 131071);
        2: set_config(0, 65535, 0);
        3: set_config(1000, 1, 65536);
        4: set_config($urandom_range(2000, 60000), 3, $urandom_range(1000, 20000));
        5: set_config($urandom_range(0, 524287), $urandom_range(2, 12),
                      $urandom_range(0, 131071));
        default: ;
      endcase
      steady = (phase == 4);
      repeat (65) begin
        send_cmd(random_cmd());
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && status_due.size() == 0) begin
      $display("motor_speed_command_supervisor_core verification clean");
    end else begin
      $display("motor_speed_command_supervisor_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mscs_pkg.sv
rtl/mscs_ctrl.sv
rtl/mscs_dp.sv
rtl/motor_speed_command_supervisor_core.sv
rtl/mscs_checker.sv
tb/motor_speed_command_supervisor_core_tb.sv
